@@ rtl/s2c_pkg.sv @@
// Shared types, constants and calendar helpers for the seconds-to-date unit.
// No dependencies; used by s2c_alu and seconds_to_calendar_date_unit.
package s2c_pkg;

  localparam int AluW = 19;

  // Bias that makes any signed 32-bit count non-negative, a whole number of days.
  localparam int DayBias = 24856;
  localparam logic [32:0] EPOCH_BIAS = 33'd2147558400;  // DayBias * 86400
  // 86400 = 675 << 7: drop the low 7 bits, then divide by 675 with a reciprocal.
  localparam logic [9:0]  DAY_ODD = 10'd675;
  localparam logic [26:0] DAY_RECIP = 27'd101806633;  // ceil(2^36 / 675), 26-bit operand
  localparam logic [16:0] SECS_PER_MIN = 17'd60;
  // 60 = 15 << 2 for both minutes and hours.
  localparam logic [15:0] MIN_RECIP = 16'd34953;  // ceil(2^19 / 15), 15-bit operand
  localparam logic [9:0]  HOUR_RECIP = 10'd547;   // ceil(2^13 / 15), 9-bit operand
  localparam logic [7:0] BASE_YEAR = 8'd70;
  localparam logic [3:0] LAST_MONTH = 4'd11;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DAY_Q,
    S_DAY_R,
    S_MIN_Q,
    S_MIN_R,
    S_HOUR_Q,
    S_HOUR_R,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  function automatic logic [8:0] year_len(input logic [7:0] yr);
    return (yr[1:0] != 2'd0) ? 9'd365 : 9'd366;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      4'd1: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/s2c_alu.sv @@
// Shared add/subtract unit for the seconds-to-date sequencer.
// Depends on s2c_pkg for the datapath width.
module s2c_alu (
  input  logic [s2c_pkg::AluW-1:0] a,
  input  logic [s2c_pkg::AluW-1:0] b,
  input  logic                     sub,
  output logic [s2c_pkg::AluW-1:0] sum
);

  assign sum = a + (sub ? ~b : b) + {{(s2c_pkg::AluW-1){1'b0}}, sub};

endmodule

@@ rtl/seconds_to_calendar_date_unit.sv @@
// Seconds-since-1970 to calendar date converter, one request at a time.
// After a request is accepted the sequencer runs the reciprocal divide and remainder
// states, then year steps (one per year stepped plus a final test), then month steps
// and the done state. busy stays high until the sequencer is back in idle, in the cycle
// after done, so a new request is taken only once the last one is through.
// Results show for one cycle on done; the receiver cannot stall. Synchronous reset
// returns the sequencer to idle.
module seconds_to_calendar_date_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds,
  output logic        done,
  output logic [5:0]  second_of_minute,
  output logic [5:0]  minute_of_hour,
  output logic [4:0]  hour_of_day,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month_number,
  output logic [7:0]  years_since_1900,
  output logic [8:0]  day_of_year
);

  s2c_pkg::state_t state, state_next;

  logic [32:0] dvd;
  logic [16:0] rem;
  logic [15:0] quo;
  logic [15:0] day;
  logic [7:0]  yr;
  logic [8:0]  dmon;
  logic [3:0]  mon;

  logic [s2c_pkg::AluW-1:0] alu_a, alu_b, alu_sum;
  logic                     alu_sub;
  logic                     neg;
  logic [25:0]              mul_a;
  logic [26:0]              mul_b;
  logic [52:0]              mul_prod;
  logic [7:0]               yr_m1;

  s2c_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  assign mul_prod = {27'b0, mul_a} * {26'b0, mul_b};
  assign neg      = alu_sum[s2c_pkg::AluW-1];
  assign yr_m1    = yr - 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= s2c_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      s2c_pkg::S_IDLE:    if (start) state_next = s2c_pkg::S_DAY_Q;
      s2c_pkg::S_DAY_Q:   state_next = s2c_pkg::S_DAY_R;
      s2c_pkg::S_DAY_R:   state_next = s2c_pkg::S_MIN_Q;
      s2c_pkg::S_MIN_Q:   state_next = s2c_pkg::S_MIN_R;
      s2c_pkg::S_MIN_R:   state_next = s2c_pkg::S_HOUR_Q;
      s2c_pkg::S_HOUR_Q:  state_next = s2c_pkg::S_HOUR_R;
      s2c_pkg::S_HOUR_R:  state_next = s2c_pkg::S_YEAR;
      s2c_pkg::S_YEAR:    if (!day[15] && neg) state_next = s2c_pkg::S_MONTH;
      s2c_pkg::S_MONTH: begin
        if (mon == s2c_pkg::LAST_MONTH || neg) state_next = s2c_pkg::S_DONE;
      end
      s2c_pkg::S_DONE:    state_next = s2c_pkg::S_IDLE;
      default:            state_next = s2c_pkg::S_IDLE;
    endcase
  end

  // Outputs and shared unit operands
  always_comb begin
    busy    = (state != s2c_pkg::S_IDLE);
    done    = (state == s2c_pkg::S_DONE);
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    mul_a   = '0;
    mul_b   = '0;
    case (state)
      s2c_pkg::S_DAY_Q: begin
        mul_a = dvd[32:7];
        mul_b = s2c_pkg::DAY_RECIP;
      end
      s2c_pkg::S_DAY_R: begin
        // Remainder of the odd part is below 675, so the low bits suffice.
        mul_a = {10'b0, quo};
        mul_b = {17'b0, s2c_pkg::DAY_ODD};
        alu_a = dvd[25:7];
        alu_b = mul_prod[18:0];
      end
      s2c_pkg::S_MIN_Q: begin
        mul_a = {11'b0, rem[16:2]};
        mul_b = {11'b0, s2c_pkg::MIN_RECIP};
      end
      s2c_pkg::S_MIN_R: begin
        mul_a = {15'b0, quo[10:0]};
        mul_b = {10'b0, s2c_pkg::SECS_PER_MIN};
        alu_a = {2'b0, rem};
        alu_b = mul_prod[18:0];
      end
      s2c_pkg::S_HOUR_Q: begin
        mul_a = {17'b0, quo[10:2]};
        mul_b = {17'b0, s2c_pkg::HOUR_RECIP};
      end
      s2c_pkg::S_HOUR_R: begin
        mul_a = {21'b0, hour_of_day};
        mul_b = {10'b0, s2c_pkg::SECS_PER_MIN};
        alu_a = {8'b0, quo[10:0]};
        alu_b = mul_prod[18:0];
      end
      s2c_pkg::S_YEAR: begin
        // Negative day count: add back the previous year; otherwise test this one.
        alu_a   = {{3{day[15]}}, day};
        alu_sub = ~day[15];
        alu_b   = day[15] ? {10'b0, s2c_pkg::year_len(yr_m1)}
                          : {10'b0, s2c_pkg::year_len(yr)};
      end
      s2c_pkg::S_MONTH: begin
        alu_a = {10'b0, dmon};
        alu_b = {14'b0, s2c_pkg::month_len(mon, yr[1:0] == 2'd0)};
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        mul_a   = '0;
        mul_b   = '0;
      end
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      s2c_pkg::S_IDLE: begin
        if (start) begin
          dvd <= {epoch_seconds[31], epoch_seconds} + s2c_pkg::EPOCH_BIAS;
        end
      end
      s2c_pkg::S_DAY_Q: begin
        quo <= mul_prod[51:36];
      end
      s2c_pkg::S_DAY_R: begin
        day <= quo - 16'(s2c_pkg::DayBias);
        rem <= {alu_sum[9:0], dvd[6:0]};
      end
      s2c_pkg::S_MIN_Q: begin
        quo <= mul_prod[34:19];
      end
      s2c_pkg::S_MIN_R: begin
        second_of_minute <= alu_sum[5:0];
      end
      s2c_pkg::S_HOUR_Q: begin
        hour_of_day <= mul_prod[17:13];
      end
      s2c_pkg::S_HOUR_R: begin
        minute_of_hour <= alu_sum[5:0];
        yr             <= s2c_pkg::BASE_YEAR;
      end
      s2c_pkg::S_YEAR: begin
        if (day[15]) begin
          day <= alu_sum[15:0];
          yr  <= yr_m1;
        end else if (!neg) begin
          day <= alu_sum[15:0];
          yr  <= yr + 8'd1;
        end else begin
          day_of_year      <= day[8:0];
          years_since_1900 <= yr;
          dmon             <= day[8:0];
          mon              <= '0;
        end
      end
      s2c_pkg::S_MONTH: begin
        if (mon == s2c_pkg::LAST_MONTH || neg) begin
          day_of_month <= dmon[4:0] + 5'd1;
          month_number <= mon + 4'd1;
        end else begin
          dmon <= alu_sum[8:0];
          mon  <= mon + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> $past(done))
    else $error("busy dropped without a result");

  a_fields_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month_number >= 4'd1 && month_number <= 4'd12 &&
              day_of_month != 5'd0 && hour_of_day <= 5'd23 &&
              minute_of_hour <= 6'd59 && second_of_minute <= 6'd59))
    else $error("result field out of range");

endmodule

@@ dv/tb_top.sv @@
// Testbench for seconds_to_calendar_date_unit: random and directed requests with
// a self-contained calendar predictor and an in-order scoreboard.
// Depends only on the RTL top level and its package.
module tb_top;

  localparam int SECONDS_PER_DAY = 86400;
  localparam int EPOCH_YEAR = 70;
  localparam int RANDOM_REQUESTS = 632;
  localparam int QUIET_TAIL = 100;
  localparam int SETTLE_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] mday;
    logic [3:0] month;
    logic [7:0] year;
    logic [8:0] yday;
  } calendar_t;

  class calendar_scoreboard;
    calendar_t pending_dates[$];
    int mismatches;
    int month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    function int year_days(int yr);
      return ((yr & 3) != 0) ? 365 : 366;
    endfunction

    // Floor-divide into days and time of day, then walk years and months.
    function calendar_t calendar_of(logic [31:0] raw);
      longint secs, tod, days;
      int yr, yday, d, mon, mlen, mins;
      calendar_t r;
      secs = $signed(raw);
      tod = secs % SECONDS_PER_DAY;
      days = secs / SECONDS_PER_DAY;
      if (tod < 0) begin
        tod += SECONDS_PER_DAY;
        days -= 1;
      end
      yr = EPOCH_YEAR;
      if (days >= 0) begin
        while (days >= year_days(yr)) begin
          days -= year_days(yr);
          yr++;
        end
      end else begin
        while (days < 0) begin
          days += year_days(yr - 1);
          yr--;
        end
      end
      yday = int'(days);
      d = yday;
      mon = 0;
      while (mon < 11) begin
        mlen = month_len[mon];
        if (mon == 1 && year_days(yr) == 366) mlen = 29;
        if (d < mlen) break;
        d -= mlen;
        mon++;
      end
      mins = int'(tod) / 60;
      r.second = 6'(int'(tod) % 60);
      r.minute = 6'(mins % 60);
      r.hour = 5'(mins / 60);
      r.mday = 5'(d + 1);
      r.month = 4'(mon + 1);
      r.year = 8'(yr);
      r.yday = 9'(yday);
      return r;
    endfunction

    function void note_request(logic [31:0] raw);
      pending_dates.push_back(calendar_of(raw));
    endfunction

    function void check_result(calendar_t got);
      calendar_t want;
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result %0d:%0d:%0d %0d/%0d/%0d yday %0d",
                   got.hour, got.minute, got.second, got.mday, got.month, got.year,
                   got.yday);
        return;
      end
      want = pending_dates.pop_front();
      if (got.second !== want.second || got.minute !== want.minute ||
          got.hour !== want.hour || got.mday !== want.mday ||
          got.month !== want.month || got.year !== want.year ||
          got.yday !== want.yday) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected %0d:%0d:%0d %0d/%0d/%0d yday %0d, got %0d:%0d:%0d %0d/%0d/%0d yday %0d",
                   want.hour, want.minute, want.second, want.mday, want.month,
                   want.year, want.yday, got.hour, got.minute, got.second,
                   got.mday, got.month, got.year, got.yday);
      end
    endfunction

    function int outstanding();
      return pending_dates.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [31:0] epoch_seconds = '0;
  logic busy, done;
  logic [5:0] second_of_minute, minute_of_hour;
  logic [4:0] hour_of_day, day_of_month;
  logic [3:0] month_number;
  logic [7:0] years_since_1900;
  logic [8:0] day_of_year;
  longint cycles = 0;

  calendar_scoreboard sb = new();

  seconds_to_calendar_date_unit u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .epoch_seconds(epoch_seconds),
    .done(done),
    .second_of_minute(second_of_minute),
    .minute_of_hour(minute_of_hour),
    .hour_of_day(hour_of_day),
    .day_of_month(day_of_month),
    .month_number(month_number),
    .years_since_1900(years_since_1900),
    .day_of_year(day_of_year)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result('{second_of_minute, minute_of_hour, hour_of_day, day_of_month,
                        month_number, years_since_1900, day_of_year});
  end

  // Hold the request until an edge with busy low takes it.
  task automatic send_request(logic [31:0] secs);
    @(negedge clk);
    start <= 1'b1;
    epoch_seconds <= secs;
    do @(posedge clk); while (busy);
    sb.note_request(secs);
  endtask

  task automatic hold_off(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_seconds();
    longint day;
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6, 7: begin
        // land on or next to a midnight
        day = longint'($urandom_range(0, 49710)) - 24855;
        v = 32'(day * SECONDS_PER_DAY + longint'($urandom_range(0, 2)) - 1);
      end
      default: v = 32'(longint'($urandom_range(0, 400000)) - 200000);
    endcase
    return v;
  endfunction

  int directed[] = '{0, 1, -1, 59, 60, 3599, 3600, 86399, 86400, -86400, -86401,
                     32'sh7FFF_FFFF, 32'sh8000_0000, 94694399, 94694400, 94608000,
                     951782399, 951782400, 951868800, -58060800, -58060801,
                     -63158400, 1234567890};

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_request(32'(directed[i]));
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 8));
    end
    drain();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      send_request(random_seconds());
      if (n % 97 == 50) drain();
      else if (n < RANDOM_REQUESTS - QUIET_TAIL && $urandom_range(0, 2) == 0)
        hold_off($urandom_range(1, 8));
    end
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.outstanding() != 0)
      $display("ERROR: %0d results never arrived", sb.outstanding());
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
